// ===== design/mrq_pkg.sv =====
`default_nettype none

package mrq_pkg;

  // Default geometry of the ring.
  localparam int DefSlots     = 16;
  localparam int DefSlotBytes = 64;

  // Item kinds. The spare kind leaves the ring alone.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

endpackage

`default_nettype wire

// ===== design/message_ring_queue.sv =====
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   kind, data_byte, byte_present, last_byte
// output    out_valid / out_stall status, read_byte, read_last, message_length,
//                                 message_count
//
// A transaction is taken in order: a read step reads the byte and length stores at
// the head slot, then an update step updates the pointers, writes back and loads
// the result; no new transaction is taken before that. A result held by out_stall
// does not block the next memory read, but stalls the update step until it leaves.
// Reset (rst, synchronous) clears the pointers, offsets, drop flag and handshake;
// the slot stores need no clearing, as only committed slots are ever read.

module message_ring_queue
  import mrq_pkg::*;
#(
  parameter int SLOTS      = DefSlots,
  parameter int SLOT_BYTES = DefSlotBytes
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_present,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [7:0]      read_byte,
  output logic            read_last,
  output logic [5:0]      message_length,
  output logic [3:0]      message_count
);

  localparam int PTR_W     = $clog2(SLOTS);
  localparam int OFF_W     = $clog2(SLOT_BYTES);
  localparam int CNT_W     = PTR_W + 1;
  localparam int MEM_DEPTH = SLOTS * (2 ** OFF_W);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);
  localparam logic [OFF_W-1:0] MAX_LEN   = OFF_W'(SLOT_BYTES - 1);

  // Memories.
  logic [7:0]       byte_mem [MEM_DEPTH];
  logic [OFF_W-1:0] len_mem  [SLOTS];
  logic [7:0]       rd_byte;
  logic [OFF_W-1:0] rd_len;

  // Control registers.
  logic [PTR_W-1:0] head_index, head_index_next;
  logic [PTR_W-1:0] tail_index, tail_index_next;
  logic [OFF_W-1:0] write_offset, write_offset_next;
  logic [OFF_W-1:0] read_offset, read_offset_next;
  logic             dropping, dropping_next;
  logic             busy;

  // Captured transaction.
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       present_q;
  logic       last_q;

  logic accept, finish;
  logic byte_we, len_we;
  logic [1:0] status_next;
  logic [7:0] rbyte_next;
  logic       rlast_next;
  logic [OFF_W-1:0] mlen_next;
  logic [PTR_W-1:0] count_now, count_after;
  logic [OFF_W:0]   read_inc;
  logic             drop_now;
  logic [31:0]      count_wide, len_wide;

  function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] h,
                                                  input logic [PTR_W-1:0] t);
    logic [CNT_W-1:0] diff;
    diff = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      diff = diff + CNT_W'(SLOTS);
    end
    return diff[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // The stored length is the offset after this transaction's byte, if any.
  function automatic logic [OFF_W-1:0] write_offset_next_len();
    return byte_we ? write_offset + 1'b1 : write_offset;
  endfunction

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign finish   = busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_byte   <= byte_mem[{head_index, read_offset}];
      rd_len    <= len_mem[head_index];
      kind_q    <= kind;
      data_q    <= data_byte;
      present_q <= byte_present;
      last_q    <= last_byte;
    end
    if (byte_we) begin
      byte_mem[{tail_index, write_offset}] <= data_q;
    end
    if (len_we) begin
      len_mem[tail_index] <= write_offset_next_len();
    end
  end

  assign count_now = ring_count(head_index, tail_index);
  assign drop_now  = dropping ||
                     (write_offset == '0 && count_now == LAST_SLOT);
  assign read_inc  = {1'b0, read_offset} + 1'b1;

  always_comb begin
    head_index_next   = head_index;
    tail_index_next   = tail_index;
    write_offset_next = write_offset;
    read_offset_next  = read_offset;
    dropping_next     = dropping;
    byte_we           = 1'b0;
    len_we            = 1'b0;
    status_next       = ST_OK;
    rbyte_next        = '0;
    rlast_next        = 1'b0;
    mlen_next         = '0;
    case (kind_q)
      KIND_WRITE: begin
        if (drop_now) begin
          status_next   = ST_FULL;
          dropping_next = !last_q;
        end else begin
          if (present_q) begin
            if (write_offset < MAX_LEN) begin
              byte_we           = finish;
              write_offset_next = write_offset + 1'b1;
            end else begin
              status_next = ST_TRUNC;
            end
          end
          if (last_q) begin
            len_we            = finish;
            tail_index_next   = ring_next(tail_index);
            write_offset_next = '0;
          end
        end
      end
      KIND_READ: begin
        if (count_now == '0) begin
          status_next = ST_EMPTY;
        end else begin
          mlen_next = rd_len;
          if (rd_len == '0 || read_offset >= rd_len) begin
            rlast_next = 1'b1;
          end else begin
            rbyte_next       = rd_byte;
            read_offset_next = read_inc[OFF_W-1:0];
            rlast_next       = (read_inc >= {1'b0, rd_len});
          end
          if (rlast_next) begin
            head_index_next  = ring_next(head_index);
            read_offset_next = '0;
          end
        end
      end
      KIND_CLEAR: begin
        head_index_next   = '0;
        tail_index_next   = '0;
        write_offset_next = '0;
        read_offset_next  = '0;
        dropping_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign count_after = ring_count(head_index_next, tail_index_next);
  assign count_wide  = 32'(count_after);
  assign len_wide    = 32'(mlen_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      head_index   <= '0;
      tail_index   <= '0;
      write_offset <= '0;
      read_offset  <= '0;
      dropping     <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid    <= 1'b1;
        head_index   <= head_index_next;
        tail_index   <= tail_index_next;
        write_offset <= write_offset_next;
        read_offset  <= read_offset_next;
        dropping     <= dropping_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status         <= status_next;
      read_byte      <= rbyte_next;
      read_last      <= rlast_next;
      message_length <= len_wide[5:0];
      message_count  <= count_wide[3:0];
    end
  end

endmodule

`default_nettype wire
